@@ hw/rtl/binary_to_decimal_ascii_top_assert.svh @@
// Assertion macros for the binary to decimal ASCII converter.
// Used by b2da_ctrl; expects clk and rst_n in scope.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// same-cycle implication
`define B2DA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B2DA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/b2da_pkg.sv @@
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies.
package b2da_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int IN_WIDTH    = 64;
    // decimal digits needed for VALUE_WIDTH bits: ceil(W * log10(2))
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103 + 99999) / 100000;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int REM_W       = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W      = 6;
    localparam int DIGIT_W     = 4;

    // ASCII '0' is 0x30; the low 6 bits are 2'b11 followed by the digit
    localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;   // load new word, zero all digits
        logic dabble;  // add-3 adjust and shift in one bit
        logic move;    // hand each digit to the next more significant cell
    } cell_ctrl_t;

endpackage

@@ hw/rtl/binary_to_decimal_ascii_top.sv @@
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_cell and b2da_ctrl.

// Takes one unsigned binary word on value (the low VALUE_WIDTH bits count)
// and returns its decimal text as a stream of output words, one ASCII digit
// per word, most significant first, no leading zeros; zero gives a single
// '0'. last_digit marks the final digit of each input word. Conversion is
// bit-serial double dabble through a row of NUM_DIGITS BCD cells: one input
// bit enters the row per cycle until all VALUE_WIDTH bits are in. The same
// row then shifts digits toward the top cell one per cycle, first dropping
// leading zeros, then emitting one digit per cycle while out_ready stays
// high. With a consumer that never stalls, the time from a word's
// acceptance to the earliest acceptance of the next word does not depend
// on the digit count. One word is in flight at a time; the final digit may
// still wait in the output register while the next word is accepted.
module binary_to_decimal_ascii_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [b2da_pkg::IN_WIDTH-1:0]    value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [b2da_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last_digit
);
    import b2da_pkg::*;

    // binary shift register feeding the row, MSB first
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    cell_ctrl_t             chain_ctrl;

    // cell 0 is the least significant digit
    logic [DIGIT_W-1:0]     digit_w [NUM_DIGITS];
    logic                   carry_w [NUM_DIGITS];

    always_comb
    begin
        value_next = value_reg;
        if (chain_ctrl.clear)
        begin
            value_next = value[VALUE_WIDTH-1:0];
        end
        else if (chain_ctrl.dabble)
        begin
            value_next = {value_reg[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                b2da_cell u_cell (
                    .clk       (clk),
                    .ctrl      (chain_ctrl),
                    .bit_in    (value_reg[VALUE_WIDTH-1]),
                    .digit_in  ('0),
                    .bit_out   (carry_w[gi]),
                    .digit_out (digit_w[gi])
                );
            end
            else
            begin : g_rest
                b2da_cell u_cell (
                    .clk       (clk),
                    .ctrl      (chain_ctrl),
                    .bit_in    (carry_w[gi-1]),
                    .digit_in  (digit_w[gi-1]),
                    .bit_out   (carry_w[gi]),
                    .digit_out (digit_w[gi])
                );
            end
        end
    endgenerate

    // top cell's carry-out is always zero: NUM_DIGITS covers the full range
    b2da_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .top_digit  (digit_w[NUM_DIGITS-1]),
        .chain_ctrl (chain_ctrl),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

@@ hw/rtl/b2da_cell.sv @@
// One BCD digit cell of the double-dabble chain.
// Depends on b2da_pkg.
module b2da_cell (
    input  logic                             clk,
    input  b2da_pkg::cell_ctrl_t             ctrl,
    input  logic                             bit_in,
    input  logic [b2da_pkg::DIGIT_W-1:0]     digit_in,
    output logic                             bit_out,
    output logic [b2da_pkg::DIGIT_W-1:0]     digit_out
);
    import b2da_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign bit_out   = adj[DIGIT_W-1];
    assign digit_out = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.move)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

@@ hw/rtl/b2da_ctrl.sv @@
// Sequencer for the converter: bit count, leading-zero skip, output register.
// Depends on b2da_pkg and binary_to_decimal_ascii_top_assert.svh.
`include "binary_to_decimal_ascii_top_assert.svh"

module b2da_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [b2da_pkg::DIGIT_W-1:0]     top_digit,
    output b2da_pkg::cell_ctrl_t             chain_ctrl,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [b2da_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last_digit
);
    import b2da_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]   remain_reg, remain_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  digit_char_reg;
    logic               last_digit_reg;
    logic               out_load;
    logic               slot_free;
    logic               skip;

    assign slot_free = !out_valid_reg || out_ready;
    assign skip      = (top_digit == '0) && (remain_reg > REM_W'(1));

    // next state
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        remain_next  = remain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next   = ST_CONV;
                    bit_cnt_next = '0;
                end
            end
            ST_CONV:
            begin
                bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                if (bit_cnt_reg == CNT_W'(VALUE_WIDTH - 1))
                begin
                    state_next  = ST_SCAN;
                    remain_next = REM_W'(NUM_DIGITS);
                end
            end
            ST_SCAN:
            begin
                if (skip)
                begin
                    remain_next = remain_reg - REM_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    remain_next = remain_reg - REM_W'(1);
                    if (remain_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready          = 1'b0;
        chain_ctrl        = '0;
        out_load          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready         = 1'b1;
                chain_ctrl.clear = in_valid;
            end
            ST_CONV:
            begin
                chain_ctrl.dabble = 1'b1;
            end
            ST_SCAN:
            begin
                chain_ctrl.move = skip;
            end
            ST_EMIT:
            begin
                out_load        = slot_free;
                chain_ctrl.move = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            digit_char_reg <= {ASCII_ZERO_HI, top_digit};
            last_digit_reg <= (remain_reg == REM_W'(1));
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last_digit = last_digit_reg;

    `B2DA_ASSERT_IMP(a_remain_nonzero, (state_reg == ST_SCAN || state_reg == ST_EMIT),
        remain_reg != '0, "digit count ran out while emitting")
    `B2DA_ASSERT_NXT(a_skip_counts, (state_reg == ST_SCAN && skip),
        remain_reg == $past(remain_reg) - REM_W'(1), "leading-zero skip lost a digit")
    `B2DA_ASSERT_NXT(a_last_ends, (out_load && remain_reg == REM_W'(1)),
        state_reg == ST_IDLE && out_valid_reg && last_digit_reg,
        "final digit did not close the word")

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for binary_to_decimal_ascii_top: random and corner binary words in,
// ASCII decimal digit stream checked against a scoreboard that does its own conversion.
// Depends on b2da_pkg and the converter RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES  = 600;   // long receiver hold-off, fills the converter
    localparam int TAIL_CYCLES  = 200;   // > one full conversion plus digit emission
    localparam int MAX_REPORTS  = 10;
    localparam int CHAR_ZERO    = 48;    // ASCII '0'
    localparam int DEC_BASE     = 10;
    localparam int MAX_DIGITS   = 20;    // decimal digits of a 64-bit word

    // One expected output word: ASCII digit and end-of-number flag.
    typedef struct packed {
        logic [b2da_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } digit_t;

    // Scoreboard: turns each accepted value into its digit string and
    // matches the output stream against it in order.
    class digit_scoreboard;
        digit_t           digits_q[$];
        int unsigned      values_seen;
        int unsigned      digits_checked;
        int unsigned      errors;
        bit [MAX_DIGITS:0] lengths_seen;

        function int unsigned pending();
            return digits_q.size();
        endfunction

        // Decimal conversion of the value (low VALUE_WIDTH bits), MSD first.
        function void note_value(logic [b2da_pkg::IN_WIDTH-1:0] v);
            logic [63:0] rest;
            logic [3:0]  dec_q[$];
            digit_t      d;
            rest = 64'(v);
            if (b2da_pkg::VALUE_WIDTH < 64)
                rest = rest & ((64'd1 << b2da_pkg::VALUE_WIDTH) - 64'd1);
            do
            begin
                dec_q.push_front(4'(rest % DEC_BASE));
                rest = rest / DEC_BASE;
            end
            while (rest != 0);
            for (int i = 0; i < dec_q.size(); i++)
            begin
                d.ch   = b2da_pkg::CHAR_W'(CHAR_ZERO + dec_q[i]);
                d.last = (i == dec_q.size() - 1);
                digits_q.push_back(d);
            end
            lengths_seen[dec_q.size()] = 1'b1;
            values_seen++;
        endfunction

        function void report(string what, digit_t want, digit_t got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("MISMATCH %s at %0t: expected char %0d last %0b, got char %0d last %0b",
                         what, $time, want.ch, want.last, got.ch, got.last);
        endfunction

        function void check_digit(logic [b2da_pkg::CHAR_W-1:0] ch, logic last);
            digit_t got;
            digit_t want;
            got.ch   = ch;
            got.last = last;
            digits_checked++;
            if (digits_q.size() == 0)
            begin
                want = '0;
                report("unexpected digit", want, got);
                return;
            end
            want = digits_q.pop_front();
            if (got.ch !== want.ch)
                report("digit_char", want, got);
            else if (got.last !== want.last)
                report("last_digit", want, got);
        endfunction
    endclass

    // ---------------------------------------------------------------
    // Clock, reset, DUT signals. Every input starts at a known value.
    // ---------------------------------------------------------------
    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_ready;
    logic [b2da_pkg::IN_WIDTH-1:0]     value     = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [b2da_pkg::CHAR_W-1:0]       digit_char;
    logic                              last_digit;

    // stimulus knobs, percent of cycles spent idle / stalled
    int unsigned                       sender_idle_pct = 0;
    int unsigned                       recv_stall_pct  = 0;
    logic                              hold_request    = 1'b0;
    int unsigned                       hold_left       = 0;

    digit_scoreboard                   sb;
    logic [b2da_pkg::IN_WIDTH-1:0]     corner_q[$] = '{
        64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd1000000,
        64'd999999999999,
        64'd9999999999999999999,        // nineteen nines
        64'd10000000000000000000,       // first twenty-digit value
        64'd12345678901234567890,
        64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,        // largest value, twenty digits
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h0000_0000_FFFF_FFFF
    };

    always #CLK_HALF clk = ~clk;

    binary_to_decimal_ascii_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request.
    // The hold-off is counted here so the sender keeps pushing words
    // into a converter that cannot drain.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_request)
        begin
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: both handshakes sampled on the edge that completes them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_value(value);
            if (out_valid && out_ready)
                sb.check_digit(digit_char, last_digit);
        end
    end

    // Random value: full width, random bit length, or near a power of ten
    // so every digit count and every carry boundary shows up.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        int unsigned nbits;
        int unsigned k;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            1, 2:
            begin
                nbits = $urandom_range(64, 1);
                v = v >> (64 - nbits);
            end
            3:
            begin
                k = $urandom_range(MAX_DIGITS - 1);
                p = 64'd1;
                repeat (k) p = p * DEC_BASE;
                v = p + $urandom_range(2) - 64'd1;
            end
            default: ;
        endcase
        return v;
    endfunction

    // Offer one word; returns on the edge where it is accepted, with valid
    // still high so a following word can go out back to back.
    task automatic send_value(input logic [63:0] v);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            value    <= {$urandom, $urandom};   // junk on an idle bus
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sender stops until every expected digit is out. One edge first so the
    // monitor has logged the word accepted on the current edge.
    task automatic wait_digits_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned count);
        sender_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        repeat (count) send_value(random_value());
        wait_digits_drained();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner values with no idling on either side
        foreach (corner_q[i])
            send_value(corner_q[i]);
        wait_digits_drained();

        // receiver holds off for a long stretch while words keep coming
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        repeat (8) send_value(random_value());
        wait_digits_drained();

        run_phase(0, 0, 25);        // full rate
        run_phase(82, 0, 30);       // sparse sender
        run_phase(0, 82, 30);       // sluggish receiver
        run_phase(27, 27, 30);      // both idle now and then
        run_phase(0, 0, 10);

        // let anything stray come out before judging
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d words into %0d digits; %0d of %0d digit counts exercised.",
                 sb.values_seen, sb.digits_checked, $countones(sb.lengths_seen), MAX_DIGITS);
        $display("Covered full-rate, sparse sender, stalled receiver, mixed idling and a long"
                 , " output hold-off; %0d mismatches.", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Watchdog expired with %0d digits outstanding.", sb.pending());
        $display("Regression FAIL");
        $finish;
    end

endmodule
